// ===== hw/rtl/pcgbr_pkg.sv =====
// Package for the bounded PCG32 random generator: types, constants and
// the small combinational helpers that the front, generator and back use.
// Depends on nothing.
`default_nettype none

package pcgbr_pkg;

    localparam logic [63:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;
    localparam logic [31:0] FULL32 = 32'hFFFF_FFFF;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INC = 2'd1;

    // The restoring divider runs one quotient bit per cycle.
    localparam logic [4:0] DIV_LAST = 5'd31;

    typedef struct packed {
        logic        bounded;
        logic [31:0] bound;
    } cmd_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } gen_rsp_t;

    typedef enum logic [2:0] {
        GS_IDLE,
        GS_MUL1,
        GS_MUL2,
        GS_ACC,
        GS_LOAD
    } gen_step_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DRAW,
        BK_DIV,
        BK_CHECK
    } back_state_t;

    typedef struct packed {
        logic [31:0] rem;
        logic        qbit;
    } div_step_t;

    // XSH RR output permutation taken from the state before the update.
    function automatic logic [31:0] xsh_rr(input logic [63:0] s);
        logic [63:0] shifted;
        logic [31:0] mixed;
        logic [4:0]  rot;
        logic [63:0] doubled;
        shifted = ((s >> 18) ^ s) >> 27;
        mixed = shifted[31:0];
        rot = s[63:59];
        doubled = {mixed, mixed} >> rot;
        return doubled[31:0];
    endfunction

    // One step of a restoring division. The remainder stays below the divisor.
    function automatic div_step_t div_step(input logic [31:0] rem, input logic din,
                                           input logic [31:0] divisor);
        div_step_t   r;
        logic [32:0] trial;
        logic [32:0] diff;
        trial = {rem, din};
        diff = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            r.rem = diff[31:0];
            r.qbit = 1'b1;
        end
        else
        begin
            r.rem = trial[31:0];
            r.qbit = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pcgbr_front.sv =====
// Front end of the bounded PCG32 generator: takes input transfers and sorts
// them into raw and bounded commands for the queue. Uses pcgbr_pkg.
`default_nettype none

module pcgbr_front (
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              mode,
    input  wire logic [31:0]       bound,
    input  wire logic              q_full,
    output logic                   q_push,
    output pcgbr_pkg::cmd_t        q_data
);

    assign in_ready = !q_full;
    assign q_push = in_valid && !q_full;

    // A zero bound has no limit to enforce, so it is served as a raw draw.
    always_comb
    begin
        q_data.bounded = mode && (bound != 32'd0);
        q_data.bound = bound;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pcgbr_queue.sv =====
// Two-entry command queue between the front and back of the bounded PCG32
// generator. Uses pcgbr_pkg for the command type.
`default_nettype none

module pcgbr_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire pcgbr_pkg::cmd_t   push_data,
    input  wire logic              pop,
    output pcgbr_pkg::cmd_t        pop_data,
    output logic                   full,
    output logic                   empty
);

    pcgbr_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pcgbr_gen.sv =====
// PCG32 XSH RR generator with the configuration registers. The 64-bit LCG
// multiply is built from partial products on one shared 32x32 multiplier.
// Uses pcgbr_pkg.
`default_nettype none

module pcgbr_gen (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [pcgbr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [63:0]                       cfg_data,
    input  wire logic                              draw_start,
    output pcgbr_pkg::gen_rsp_t                    rsp
);

    pcgbr_pkg::gen_step_t step_reg;
    pcgbr_pkg::gen_step_t step_next;

    logic [63:0] state_reg;
    logic [63:0] inc_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;
    logic [31:0] value_reg;
    logic [31:0] mult_a;
    logic [31:0] mult_b;
    logic [63:0] mult_p;

    localparam logic [31:0] MULT_LO = pcgbr_pkg::LCG_MULT[31:0];
    localparam logic [31:0] MULT_HI = pcgbr_pkg::LCG_MULT[63:32];

    always_comb
    begin
        step_next = step_reg;
        case (step_reg)
            pcgbr_pkg::GS_IDLE:
            begin
                if (draw_start)
                begin
                    step_next = pcgbr_pkg::GS_MUL1;
                end
            end
            pcgbr_pkg::GS_MUL1: step_next = pcgbr_pkg::GS_MUL2;
            pcgbr_pkg::GS_MUL2: step_next = pcgbr_pkg::GS_ACC;
            pcgbr_pkg::GS_ACC:  step_next = pcgbr_pkg::GS_LOAD;
            pcgbr_pkg::GS_LOAD: step_next = pcgbr_pkg::GS_IDLE;
            default:            step_next = pcgbr_pkg::GS_IDLE;
        endcase
    end

    // Operand selection for the partial products of the low 64 bits.
    always_comb
    begin
        case (step_reg)
            pcgbr_pkg::GS_MUL1:
            begin
                mult_a = state_reg[31:0];
                mult_b = MULT_HI;
            end
            pcgbr_pkg::GS_MUL2:
            begin
                mult_a = state_reg[63:32];
                mult_b = MULT_LO;
            end
            default:
            begin
                mult_a = state_reg[31:0];
                mult_b = MULT_LO;
            end
        endcase
        rsp.done = (step_reg == pcgbr_pkg::GS_LOAD);
        rsp.value = value_reg;
    end

    assign mult_p = mult_a * mult_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= pcgbr_pkg::GS_IDLE;
            state_reg <= 64'd0;
            inc_reg <= 64'd0;
        end
        else
        begin
            step_reg <= step_next;
            if (cfg_write && (cfg_index == pcgbr_pkg::CFG_SEED))
            begin
                state_reg <= cfg_data;
            end
            else if (step_reg == pcgbr_pkg::GS_LOAD)
            begin
                state_reg <= acc_reg + {inc_reg[63:1], 1'b1};
            end
            if (cfg_write && (cfg_index == pcgbr_pkg::CFG_INC))
            begin
                inc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mult_p;
        case (step_reg)
            pcgbr_pkg::GS_IDLE:
            begin
                if (draw_start)
                begin
                    value_reg <= pcgbr_pkg::xsh_rr(state_reg);
                end
            end
            pcgbr_pkg::GS_MUL1: acc_reg <= prod_reg;
            pcgbr_pkg::GS_MUL2: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            pcgbr_pkg::GS_ACC:  acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            default:            acc_reg <= acc_reg;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pcgbr_back.sv =====
// Back end of the bounded PCG32 generator: draws, runs the rejection test
// and the modulo on two lockstep restoring dividers, and holds the result.
// Uses pcgbr_pkg.
`default_nettype none

module pcgbr_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_empty,
    input  wire pcgbr_pkg::cmd_t       q_data,
    output logic                       q_pop,
    output logic                       draw_start,
    input  wire pcgbr_pkg::gen_rsp_t   rsp,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [31:0]                value
);

    pcgbr_pkg::back_state_t state_reg;
    pcgbr_pkg::back_state_t state_next;

    pcgbr_pkg::cmd_t cmd_reg;
    logic [31:0] xq_reg;
    logic [31:0] xrem_reg;
    logic [31:0] fq_reg;
    logic [31:0] frem_reg;
    logic [4:0]  cnt_reg;
    logic        out_valid_reg;
    logic [31:0] value_reg;

    logic        div_load;
    logic        out_load;
    logic [31:0] out_data;
    logic        accept;

    pcgbr_pkg::div_step_t xstep;
    pcgbr_pkg::div_step_t fstep;

    assign out_valid = out_valid_reg;
    assign value = value_reg;

    // x is below floor(FULL32/bound)*bound exactly when its quotient is
    // below the quotient of FULL32.
    assign accept = (xq_reg < fq_reg);

    assign xstep = pcgbr_pkg::div_step(xrem_reg, xq_reg[31], cmd_reg.bound);
    assign fstep = pcgbr_pkg::div_step(frem_reg, fq_reg[31], cmd_reg.bound);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcgbr_pkg::BK_IDLE:
            begin
                if (!q_empty && !out_valid_reg)
                begin
                    state_next = pcgbr_pkg::BK_DRAW;
                end
            end
            pcgbr_pkg::BK_DRAW:
            begin
                if (rsp.done)
                begin
                    state_next = cmd_reg.bounded ? pcgbr_pkg::BK_DIV : pcgbr_pkg::BK_IDLE;
                end
            end
            pcgbr_pkg::BK_DIV:
            begin
                if (cnt_reg == pcgbr_pkg::DIV_LAST)
                begin
                    state_next = pcgbr_pkg::BK_CHECK;
                end
            end
            pcgbr_pkg::BK_CHECK:
            begin
                state_next = accept ? pcgbr_pkg::BK_IDLE : pcgbr_pkg::BK_DRAW;
            end
            default: state_next = pcgbr_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        draw_start = 1'b0;
        div_load = 1'b0;
        out_load = 1'b0;
        out_data = rsp.value;
        case (state_reg)
            pcgbr_pkg::BK_IDLE:
            begin
                q_pop = !q_empty && !out_valid_reg;
                draw_start = q_pop;
            end
            pcgbr_pkg::BK_DRAW:
            begin
                out_load = rsp.done && !cmd_reg.bounded;
                div_load = rsp.done && cmd_reg.bounded;
            end
            pcgbr_pkg::BK_CHECK:
            begin
                out_load = accept;
                draw_start = !accept;
                out_data = xrem_reg;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcgbr_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_data;
        end
        if (out_load)
        begin
            value_reg <= out_data;
        end
        if (div_load)
        begin
            xq_reg <= rsp.value;
            xrem_reg <= 32'd0;
            fq_reg <= pcgbr_pkg::FULL32;
            frem_reg <= 32'd0;
            cnt_reg <= 5'd0;
        end
        else if (state_reg == pcgbr_pkg::BK_DIV)
        begin
            // Dividend bits shift out at the top while quotient bits enter below.
            xq_reg <= {xq_reg[30:0], xstep.qbit};
            xrem_reg <= xstep.rem;
            fq_reg <= {fq_reg[30:0], fstep.qbit};
            frem_reg <= fstep.rem;
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pcg32_bounded_random.sv =====
// Top level of the bounded PCG32 random generator. It ties the front end,
// command queue, generator and back end together. Uses pcgbr_pkg.
//
// Usage: write seed_state (index 0) and increment (index 1) on the cfg
// channel while the block is idle; cfg_ready is always high. Each input
// transfer (mode, bound) yields exactly one output transfer on value.
// Mode 0, or a bound of zero, gives one raw draw. Mode 1 gives a value
// below bound, redrawing while the draw falls in the biased top range.
// Steps: a raw item takes one draw through the generator update on its
// shared 32x32 multiplier, then loads the output register. A bounded
// item runs, for each draw, the generator update, the bit-serial divider
// and the check, and redraws until the check accepts. The next item
// starts the cycle after the output transfer if one is queued.
// A two-entry queue takes inputs while the back end works; the back end
// starts the next item only once the output register is free, so a
// stalled receiver holds value steady and fills the queue, after which
// in_ready falls. Reset clears the generator state and increment to zero
// and empties the queue and output register.
`default_nettype none

module pcg32_bounded_random (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pcgbr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [63:0]                       cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              mode,
    input  wire logic [31:0]                       bound,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [31:0]                            value
);

    pcgbr_pkg::cmd_t     push_data;
    pcgbr_pkg::cmd_t     pop_data;
    pcgbr_pkg::gen_rsp_t rsp;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_empty;
    logic                draw_start;

    assign cfg_ready = 1'b1;

    pcgbr_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .bound    (bound),
        .q_full   (q_full),
        .q_push   (push),
        .q_data   (push_data)
    );

    pcgbr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    pcgbr_gen u_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .draw_start (draw_start),
        .rsp        (rsp)
    );

    pcgbr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (pop_data),
        .q_pop      (pop),
        .draw_start (draw_start),
        .rsp        (rsp),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the bounded PCG32 random generator.
// Sends raw and bounded draw requests and checks every value against a built-in predictor.
// Depends on pcgbr_pkg and pcg32_bounded_random.

module tb_top;

    localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
    localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
    localparam logic [63:0] ALL_ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic MODE_RAW = 1'b0;
    localparam logic MODE_BOUNDED = 1'b1;
    localparam logic [pcgbr_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [pcgbr_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 80;
    localparam int IDLE_PCT = 24;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 205;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pcgbr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]                     cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic                            mode = MODE_RAW;
    logic [31:0]                     bound = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [31:0]                     value;

    // Predictor copy of the generator: both registers reset to zero.
    logic [63:0] lcg_state = '0;
    logic [63:0] inc_reg = '0;
    logic [31:0] pending_values[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          steady_flow = 1'b0;

    pcg32_bounded_random DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .bound     (bound),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advances the LCG and returns the XSH RR permutation of the old state.
    function automatic logic [31:0] draw_word();
        logic [63:0] prior;
        logic [31:0] mixed;
        logic [4:0]  rot;
        int unsigned left;
        prior = lcg_state;
        lcg_state = prior * PCG_MULT + (inc_reg | 64'd1);
        mixed = 32'(((prior >> 18) ^ prior) >> 27);
        rot = prior[63:59];
        left = (32 - rot) & 31;
        return (mixed >> rot) | (mixed << left);
    endfunction

    function automatic logic [31:0] predict_value(input logic m, input logic [31:0] b);
        logic [31:0] limit;
        logic [31:0] x;
        if (m == MODE_RAW || b == 32'd0)
            return draw_word();
        limit = (ALL_ONES32 / b) * b;
        do
            x = draw_word();
        while (x >= limit);
        return x % b;
    endfunction

    function automatic int idle_cycles();
        int n;
        n = 0;
        if (!steady_flow)
            while ($urandom_range(99) < IDLE_PCT)
                n++;
        return n;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] pick_bound();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 35)
            return $urandom_range(16, 1);
        if (sel < 55)
            return $urandom_range(1000, 17);
        if (sel < 80)
            return $urandom;
        // Just above half range, where about half of all draws are rejected.
        if (sel < 90)
            return 32'h8000_0000 + $urandom_range(64);
        if (sel < 95)
            return 32'd0;
        return ALL_ONES32 - $urandom_range(3);
    endfunction

    // Always entered just after the clock rises; leaves valid high after the transfer.
    task automatic send_item(input logic m, input logic [31:0] b);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        bound <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_values.push_back(predict_value(m, b));
    endtask

    task automatic send_random_item();
        send_item(($urandom_range(3) != 0) ? MODE_BOUNDED : MODE_RAW, pick_bound());
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_values.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [pcgbr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == pcgbr_pkg::CFG_SEED)
            lcg_state = data;
        else if (idx == pcgbr_pkg::CFG_INC)
            inc_reg = data;
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic load_generator(input logic [63:0] seed, input logic [63:0] inc);
        wait_idle();
        write_reg(pcgbr_pkg::CFG_INC, inc, 1'b0);
        write_reg(pcgbr_pkg::CFG_SEED, seed, 1'b1);
    endtask

    // Draws straight out of reset use a zero state and a zero increment.
    task automatic test_reset_state();
        send_item(MODE_RAW, 32'd0);
        send_item(MODE_RAW, ALL_ONES32);
        send_item(MODE_BOUNDED, 32'd10);
    endtask

    // Writes to indexes past the register list must leave the generator alone.
    task automatic test_spare_index();
        wait_idle();
        write_reg(CFG_SPARE_LO, rand64(), 1'b0);
        write_reg(CFG_SPARE_HI, rand64(), 1'b1);
        send_item(MODE_RAW, 32'd0);
        send_item(MODE_BOUNDED, 32'd6);
        send_item(MODE_BOUNDED, $urandom);
    endtask

    task automatic test_register_extremes();
        load_generator(ALL_ONES64, ALL_ONES64);
        send_item(MODE_RAW, 32'd0);
        send_item(MODE_RAW, 32'd0);
        send_item(MODE_BOUNDED, ALL_ONES32);
        // An even increment still steps by an odd amount.
        load_generator(64'd0, 64'd0);
        send_item(MODE_RAW, 32'd0);
        send_item(MODE_RAW, 32'd0);
        send_item(MODE_BOUNDED, 32'd2);
    endtask

    task automatic test_bound_corners();
        load_generator(64'h853C_49E6_748F_EA9B, 64'hDA3E_39CB_94B9_5BDB);
        send_item(MODE_RAW, 32'h1234_5678);
        send_item(MODE_BOUNDED, 32'd0);
        send_item(MODE_BOUNDED, 32'd1);
        send_item(MODE_BOUNDED, 32'd1);
        send_item(MODE_BOUNDED, 32'd2);
        send_item(MODE_BOUNDED, 32'd3);
        send_item(MODE_BOUNDED, ALL_ONES32);
        send_item(MODE_BOUNDED, ALL_ONES32 - 32'd1);
        send_item(MODE_BOUNDED, 32'h7FFF_FFFF);
        send_item(MODE_BOUNDED, 32'h8000_0000);
        send_item(MODE_BOUNDED, 32'h8000_0001);
        send_item(MODE_BOUNDED, 32'h8000_0001);
        send_item(MODE_BOUNDED, 32'h8000_0001);
    endtask

    // Sends 40 items without waiting for results, waits until every outstanding value has come back, and sends 40 more.
    task automatic test_pressure();
        load_generator(rand64(), rand64());
        repeat (40)
            send_random_item();
        wait_idle();
        repeat (40)
            send_random_item();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            load_generator(rand64(), rand64());
            steady_flow = (phase == 0);
            repeat (PHASE_ITEMS)
                send_random_item();
        end
        steady_flow = 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        logic [31:0] want;
        out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_values.size() == 0)
            begin
                $error("value: expected none, actual %08h", value);
                fail_count++;
            end
            else
            begin
                want = pending_values.pop_front();
                if (value !== want)
                begin
                    $error("value: expected %08h, actual %08h", want, value);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_spare_index();
        test_register_extremes();
        test_bound_corners();
        test_pressure();
        test_random_phases();
        wait_idle();
        // Any transfer after the last expected one shows up as a failure here.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pcgbr_pkg.sv
hw/rtl/pcgbr_front.sv
hw/rtl/pcgbr_queue.sv
hw/rtl/pcgbr_gen.sv
hw/rtl/pcgbr_back.sv
hw/rtl/pcg32_bounded_random.sv
tb/sv/tb_top.sv
